### rtl/core/stsf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the script text span finder.
// No dependencies; imported by script_text_span_finder and its testbench.
package stsf_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int UNIT_W = 16;
  localparam int SKIP_W = 3;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_TEXT  = 2'd1,
    MODE_RUBY  = 2'd2,
    MODE_VOICE = 2'd3
  } mode_t;

  localparam logic [UNIT_W-1:0] NUL_CODE    = 16'h0000;
  localparam logic [UNIT_W-1:0] LF_CODE     = 16'h000A;
  localparam logic [UNIT_W-1:0] ESC_CODE    = 16'h0007;
  localparam logic [UNIT_W-1:0] OP_CODE_MIN = 16'h0001;
  localparam logic [UNIT_W-1:0] OP_CODE_MAX = 16'h0006;
  localparam logic [UNIT_W-1:0] SUB_RUBY    = 16'h0001;
  localparam logic [UNIT_W-1:0] SUB_VOICE   = 16'h0008;
  localparam logic [UNIT_W-1:0] SUB_SKIP    = 16'h0007;

  // operand units that follow control codes 1..6
  function automatic logic [SKIP_W-1:0] operand_len(input logic [2:0] code);
    logic [SKIP_W-1:0] len;
    case (code)
      3'd1:    len = 3'd4;
      3'd2:    len = 3'd1;
      3'd3:    len = 3'd2;
      3'd4:    len = 3'd1;
      3'd5:    len = 3'd2;
      3'd6:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/script_text_span_finder.sv
`timescale 1ns / 1ps
// Script text span finder: scans 16-bit code units and reports text spans.
// Depends on stsf_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready): one code unit per transaction, with
//   last_unit marking the final unit of a string. After that unit all parse
//   state returns to its reset value; a span still open is dropped.
//   Output channel (out_valid/out_ready): one transaction per closed span,
//   span_start = first unit position, span_end = position of the control
//   unit that ended it (exclusive).
// Timing:
//   One code unit per cycle sustained, except while a span waits on a
//   stalled output. The parse state updates in the cycle a unit is
//   accepted; a span appears on the output in the cycle after. The output
//   register holds a span until taken; in_ready stays high while that
//   register is empty or being drained in the same cycle.
// Reset:
//   rst (synchronous) puts the parser in init mode at position zero and
//   empties the output register. Position saturates at its maximum; output
//   positions carry its low 16 bits.
module script_text_span_finder #(
  parameter int POSITION_BITS = stsf_pkg::POSITION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [stsf_pkg::UNIT_W-1:0]   code_unit,
  input  logic                          last_unit,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stsf_pkg::UNIT_W-1:0]   span_start,
  output logic [stsf_pkg::UNIT_W-1:0]   span_end
);
  import stsf_pkg::*;

  mode_t                    parse_mode, parse_mode_next;
  logic                     span_open, span_open_next;
  logic [POSITION_BITS-1:0] span_begin, span_begin_next;
  logic [SKIP_W-1:0]        skip_count, skip_count_next;
  logic                     escape_pending, escape_pending_next;
  logic                     skip_to_terminator, skip_to_terminator_next;
  logic [POSITION_BITS-1:0] position, position_next;
  logic [POSITION_BITS-1:0] escape_at, escape_at_next;

  logic                     emit;
  logic [POSITION_BITS-1:0] end_pos;
  logic [UNIT_W-1:0]        start_ext, end_ext;
  logic                     in_fire;
  logic                     is_line, is_op;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign is_line  = (code_unit == NUL_CODE) || (code_unit == LF_CODE);
  assign is_op    = (code_unit >= OP_CODE_MIN) && (code_unit <= OP_CODE_MAX);

  always_comb begin
    parse_mode_next         = parse_mode;
    span_open_next          = span_open;
    span_begin_next         = span_begin;
    skip_count_next         = skip_count;
    escape_pending_next     = escape_pending;
    skip_to_terminator_next = skip_to_terminator;
    escape_at_next          = escape_at;
    emit                    = 1'b0;
    end_pos                 = position;

    if (skip_count != '0) begin
      skip_count_next = skip_count - 1'b1;
    end else if (skip_to_terminator) begin
      if (code_unit == NUL_CODE) skip_to_terminator_next = 1'b0;
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      if (code_unit == SUB_RUBY) begin
        if (parse_mode == MODE_INIT) begin
          span_begin_next = escape_at;
          span_open_next  = 1'b1;
        end
        parse_mode_next = MODE_RUBY;
      end else begin
        parse_mode_next = (code_unit == SUB_VOICE) ? MODE_VOICE : MODE_INIT;
        if (code_unit == SUB_SKIP) skip_to_terminator_next = 1'b1;
        emit           = span_open;
        end_pos        = escape_at;
        span_open_next = 1'b0;
      end
    end else if (is_line) begin
      if (parse_mode != MODE_RUBY) begin
        parse_mode_next = MODE_INIT;
        emit            = span_open;
        span_open_next  = 1'b0;
      end
    end else if (is_op) begin
      parse_mode_next = MODE_INIT;
      emit            = span_open;
      span_open_next  = 1'b0;
      skip_count_next = operand_len(code_unit[2:0]);
    end else if (code_unit == ESC_CODE) begin
      escape_pending_next = 1'b1;
      escape_at_next      = position;
    end else if (parse_mode == MODE_INIT || parse_mode == MODE_VOICE) begin
      parse_mode_next = MODE_TEXT;
      span_begin_next = position;
      span_open_next  = 1'b1;
    end

    // saturating position counter
    position_next = (position == '1) ? position : position + 1'b1;

    if (last_unit) begin
      parse_mode_next         = MODE_INIT;
      span_open_next          = 1'b0;
      span_begin_next         = '0;
      skip_count_next         = '0;
      escape_pending_next     = 1'b0;
      skip_to_terminator_next = 1'b0;
      position_next           = '0;
      escape_at_next          = '0;
    end
  end

  // output positions carry the low 16 bits
  generate
    if (POSITION_BITS >= UNIT_W) begin : g_trunc
      assign start_ext = span_begin[UNIT_W-1:0];
      assign end_ext   = end_pos[UNIT_W-1:0];
    end else begin : g_ext
      assign start_ext = {{(UNIT_W-POSITION_BITS){1'b0}}, span_begin};
      assign end_ext   = {{(UNIT_W-POSITION_BITS){1'b0}}, end_pos};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode         <= MODE_INIT;
      span_open          <= 1'b0;
      span_begin         <= '0;
      skip_count         <= '0;
      escape_pending     <= 1'b0;
      skip_to_terminator <= 1'b0;
      position           <= '0;
      escape_at          <= '0;
    end else if (in_fire) begin
      parse_mode         <= parse_mode_next;
      span_open          <= span_open_next;
      span_begin         <= span_begin_next;
      skip_count         <= skip_count_next;
      escape_pending     <= escape_pending_next;
      skip_to_terminator <= skip_to_terminator_next;
      position           <= position_next;
      escape_at          <= escape_at_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      span_start <= start_ext;
      span_end   <= end_ext;
    end
  end

`ifndef SYNTHESIS
  // operand skip, terminator skip and escape are mutually exclusive
  a_skip_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({skip_count != '0, escape_pending, skip_to_terminator}))
    else $error("more than one skip/escape state active");

  // an open span only lives in text or ruby mode
  a_open_mode: assert property (@(posedge clk) disable iff (rst)
    span_open |-> (parse_mode == MODE_TEXT || parse_mode == MODE_RUBY))
    else $error("span open outside text/ruby mode");

  // final unit clears the parser
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_unit |=> position == '0 && !span_open && parse_mode == MODE_INIT)
    else $error("state not cleared after last unit");

  // position never wraps back to zero on an ordinary unit
  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    in_fire && !last_unit |=> position != '0)
    else $error("position wrapped");
`endif

endmodule

### dv/script_text_span_finder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for script_text_span_finder: queue-fed driver,
// clocked monitor and an in-bench span predictor. Depends on stsf_pkg.
module script_text_span_finder_tb;
  import stsf_pkg::*;

  typedef struct packed {
    logic [UNIT_W-1:0] cu;
    logic              fin;
  } unit_t;

  typedef struct packed {
    logic [UNIT_W-1:0] first;
    logic [UNIT_W-1:0] stop;
  } span_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [UNIT_W-1:0] code_unit = '0;
  logic              last_unit = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [UNIT_W-1:0] span_start;
  logic [UNIT_W-1:0] span_end;

  script_text_span_finder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_unit (code_unit),
    .last_unit (last_unit),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .span_start(span_start),
    .span_end  (span_end)
  );

  unit_t units_pending[$];
  span_t spans_due[$];
  int    errors = 0;
  int    units_queued = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  logic  in_taken = 1'b0;
  unit_t drv_unit;

  // predicted parser state
  mode_t             cur_mode;
  logic              span_live;
  logic [UNIT_W-1:0] open_at;
  logic [SKIP_W-1:0] skip_left;
  logic              esc_seen;
  logic              drain_to_nul;
  logic [UNIT_W-1:0] unit_pos;
  logic [UNIT_W-1:0] esc_pos;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [SKIP_W-1:0] operand_units(input logic [UNIT_W-1:0] c);
    logic [SKIP_W-1:0] n;
    case (c)
      16'd1:   n = 3'd4;
      16'd2:   n = 3'd1;
      16'd3:   n = 3'd2;
      16'd4:   n = 3'd1;
      16'd5:   n = 3'd2;
      16'd6:   n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  task automatic clear_parse();
    cur_mode     = MODE_INIT;
    span_live    = 1'b0;
    open_at      = '0;
    skip_left    = '0;
    esc_seen     = 1'b0;
    drain_to_nul = 1'b0;
    unit_pos     = '0;
    esc_pos      = '0;
  endtask

  task automatic close_at(input logic [UNIT_W-1:0] stop);
    span_t sp;
    if (span_live) begin
      sp.first = open_at;
      sp.stop  = stop;
      spans_due.insert(spans_due.size(), sp);
      span_live = 1'b0;
    end
  endtask

  task automatic predict_unit(input logic [UNIT_W-1:0] cu, input logic fin);
    if (skip_left != '0) begin
      skip_left = skip_left - 1'b1;
    end else if (drain_to_nul) begin
      if (cu == NUL_CODE) drain_to_nul = 1'b0;
    end else if (esc_seen) begin
      esc_seen = 1'b0;
      if (cu == SUB_RUBY) begin
        if (cur_mode == MODE_INIT) begin
          open_at   = esc_pos;
          span_live = 1'b1;
        end
        cur_mode = MODE_RUBY;
      end else begin
        if (cu == SUB_VOICE) cur_mode = MODE_VOICE;
        else cur_mode = MODE_INIT;
        if (cu == SUB_SKIP) drain_to_nul = 1'b1;
        close_at(esc_pos);
      end
    end else if (cu == NUL_CODE || cu == LF_CODE) begin
      if (cur_mode != MODE_RUBY) begin
        cur_mode = MODE_INIT;
        close_at(unit_pos);
      end
    end else if (cu >= OP_CODE_MIN && cu <= OP_CODE_MAX) begin
      cur_mode = MODE_INIT;
      close_at(unit_pos);
      skip_left = operand_units(cu);
    end else if (cu == ESC_CODE) begin
      esc_seen = 1'b1;
      esc_pos  = unit_pos;
    end else if (cur_mode != MODE_TEXT && cur_mode != MODE_RUBY) begin
      cur_mode  = MODE_TEXT;
      open_at   = unit_pos;
      span_live = 1'b1;
    end
    // position saturates
    if (unit_pos != '1) unit_pos = unit_pos + 1'b1;
    if (fin) clear_parse();
  endtask

  // driver: new transaction only when the previous one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (units_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_unit = units_pending.pop_front();
          code_unit <= drv_unit.cu;
          last_unit <= drv_unit.fin;
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    span_t sp;
    in_taken <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) predict_unit(code_unit, last_unit);
      if (out_valid && out_ready) begin
        if (spans_due.size() == 0) begin
          $error("unexpected span transaction start=%h end=%h", span_start, span_end);
          errors++;
        end else begin
          sp = spans_due.pop_front();
          if (span_start !== sp.first) begin
            $error("span_start expected %h got %h", sp.first, span_start);
            errors++;
          end
          if (span_end !== sp.stop) begin
            $error("span_end expected %h got %h", sp.stop, span_end);
            errors++;
          end
        end
      end
    end
  end

  task automatic push_unit(input logic [UNIT_W-1:0] cu, input logic fin);
    unit_t u;
    u.cu  = cu;
    u.fin = fin;
    units_pending.insert(units_pending.size(), u);
    units_queued++;
  endtask

  function automatic logic [UNIT_W-1:0] random_unit();
    if ($urandom_range(0, 1) == 0) return UNIT_W'($urandom_range(0, 15));
    return UNIT_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [UNIT_W-1:0] printable_unit();
    logic [UNIT_W-1:0] u;
    do begin
      u = random_unit();
    end while (u <= ESC_CODE || u == LF_CODE);
    return u;
  endfunction

  // well-formed string of segments; broken strings end at a random point
  task automatic add_string(input int segs, input bit broken);
    logic [UNIT_W-1:0] s[$];
    logic [UNIT_W-1:0] c;
    int n;
    for (int k = 0; k < segs; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(1, 6);
          repeat (n) s.insert(s.size(), printable_unit());
        end
        4: begin
          c = UNIT_W'($urandom_range(1, 6));
          s.insert(s.size(), c);
          repeat (operand_units(c)) s.insert(s.size(), random_unit());
        end
        5: begin
          s.insert(s.size(), ESC_CODE);
          s.insert(s.size(), SUB_RUBY);
        end
        6: begin
          s.insert(s.size(), ESC_CODE);
          s.insert(s.size(), SUB_VOICE);
        end
        7: begin
          s.insert(s.size(), ESC_CODE);
          s.insert(s.size(), SUB_SKIP);
          n = $urandom_range(0, 4);
          repeat (n) s.insert(s.size(), printable_unit());
          s.insert(s.size(), NUL_CODE);
        end
        8: begin
          s.insert(s.size(), ESC_CODE);
          s.insert(s.size(), random_unit());
        end
        default: s.insert(s.size(), $urandom_range(0, 1) ? NUL_CODE : LF_CODE);
      endcase
    end
    if (broken) begin
      n = $urandom_range(1, s.size());
      while (s.size() > n) void'(s.pop_back());
    end
    foreach (s[i]) push_unit(s[i], i == s.size() - 1);
  endtask

  task automatic add_random(input int target);
    int goal;
    goal = units_queued + target;
    while (units_queued < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: add_string($urandom_range(1, 8), 1'b0);
        7, 8: add_string($urandom_range(1, 8), 1'b1);
        default: begin
          repeat ($urandom_range(1, 12)) push_unit(random_unit(), $urandom_range(0, 15) == 0);
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    wait (units_pending.size() == 0);
    @(posedge clk);
    wait (!in_valid);
    wait (spans_due.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clear_parse();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no idling: directed cases, a long text run, then random strings
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_unit(16'h0041, 1'b0);      // text opens at 0
    push_unit(16'hFFFF, 1'b0);
    push_unit(NUL_CODE, 1'b0);      // closes
    push_unit(16'h0008, 1'b0);      // text opens
    push_unit(ESC_CODE, 1'b0);
    push_unit(SUB_RUBY, 1'b0);      // ruby from text keeps span
    push_unit(16'h0041, 1'b0);
    push_unit(LF_CODE, 1'b0);       // line controls ignored in ruby
    push_unit(NUL_CODE, 1'b0);
    push_unit(ESC_CODE, 1'b0);
    push_unit(SUB_VOICE, 1'b0);     // closes at escape position
    push_unit(16'h0042, 1'b0);      // text in voice opens
    push_unit(16'h0003, 1'b0);      // closes, two operands follow
    push_unit(ESC_CODE, 1'b0);
    push_unit(NUL_CODE, 1'b0);
    push_unit(ESC_CODE, 1'b0);
    push_unit(SUB_SKIP, 1'b0);      // skip through next zero
    push_unit(16'h0041, 1'b0);
    push_unit(NUL_CODE, 1'b0);
    push_unit(ESC_CODE, 1'b0);
    push_unit(SUB_RUBY, 1'b0);      // ruby from init opens at escape
    push_unit(ESC_CODE, 1'b0);
    push_unit(16'h0005, 1'b0);      // other subcode closes
    push_unit(16'h0061, 1'b1);      // open span dropped on last
    push_unit(16'h0001, 1'b0);
    push_unit(16'h7FFF, 1'b1);      // string ends inside operand skip
    push_unit(ESC_CODE, 1'b1);      // string ends on an escape
    for (int i = 0; i < 200; i++) begin
      if (i % 70 == 69) push_unit(LF_CODE, 1'b0);
      else push_unit(printable_unit(), 1'b0);
    end
    push_unit(16'h0004, 1'b0);
    push_unit(16'h0063, 1'b0);
    push_unit(16'h0041, 1'b0);
    push_unit(NUL_CODE, 1'b1);
    add_random(400);
    wait_drained();

    send_idle_pct  = 49;
    recv_stall_pct = 0;
    add_random(400);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 49;
    add_random(400);
    wait_drained();

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    add_random(400);
    wait_drained();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
